### rtl/core/yrbd_pkg.sv
// Package for the region box decoder: fixed-point constants, config indices and a helper function.
// Used by yrbd_exp and yolo_region_box_decoder_unit; no dependencies.
package yrbd_pkg;

    localparam int COORD_COUNT       = 4;
    localparam int FIRST_CLASS_ENTRY = 5;

    localparam logic [17:0] LOG2E_Q16 = 18'd94548;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [3:0]  TERM_LAST = 4'd10;
    localparam logic [15:0] SAT16     = 16'hFFFF;
    localparam logic [14:0] SAT15     = 15'h7FFF;

    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_CLASSES   = 3'd1;
    localparam logic [2:0] CFG_GRID      = 3'd2;
    localparam logic [2:0] CFG_IMAGE     = 3'd3;
    localparam logic [2:0] CFG_SOFTMAX   = 3'd4;
    localparam logic [2:0] CFG_ANCHORS   = 3'd5;

    // floor((2^32-1)/k) for the Taylor term divisors
    function automatic logic [31:0] term_recip(input logic [3:0] k);
        logic [31:0] r;
        begin
            case (k)
                4'd1:    r = 32'hFFFFFFFF;
                4'd2:    r = 32'h7FFFFFFF;
                4'd3:    r = 32'h55555555;
                4'd4:    r = 32'h3FFFFFFF;
                4'd5:    r = 32'h33333333;
                4'd6:    r = 32'h2AAAAAAA;
                4'd7:    r = 32'h24924924;
                4'd8:    r = 32'h1FFFFFFF;
                4'd9:    r = 32'h1C71C71C;
                4'd10:   r = 32'h19999999;
                default: r = 32'hFFFFFFFF;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/core/yrbd_exp.sv
// Iterative exponential of a signed Q4.12 value, result unsigned Q.12.
// Power-of-two split and ten Taylor terms through one shared 32x32 multiplier; uses yrbd_pkg.
module yrbd_exp
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] x,
    output logic               done,
    output logic [23:0]        result
);

    typedef enum logic [5:0] {
        E_IDLE  = 6'b000001,
        E_FRAC  = 6'b000010,
        E_TERM  = 6'b000100,
        E_DIV   = 6'b001000,
        E_FIX   = 6'b010000,
        E_ROUND = 6'b100000
    } exp_state_t;

    exp_state_t        state_reg;
    logic [27:0]       g_reg;
    logic [4:0]        sh_reg;
    logic [29:0]       r_reg;
    logic [30:0]       term_reg;
    logic [30:0]       t_reg;
    logic [30:0]       q_reg;
    logic [31:0]       sum_reg;
    logic [3:0]        k_reg;
    logic              done_reg;
    logic [23:0]       result_reg;

    logic signed [34:0] y;
    logic [32:0]        u;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [34:0]        qk;
    logic [31:0]        rem;
    logic [30:0]        q_fix;
    logic [32:0]        rnd;

    assign y = 35'(x) * $signed({1'b0, yrbd_pkg::LOG2E_Q16});
    assign u = 33'(y + 35'sh100000000);

    always_comb
    begin
        mul_a = 32'(term_reg);
        mul_b = 32'(r_reg);
        case (state_reg)
            E_FRAC:
            begin
                mul_a = 32'(g_reg);
                mul_b = 32'(yrbd_pkg::LN2_Q30);
            end
            E_DIV:
            begin
                mul_a = 32'(t_reg);
                mul_b = yrbd_pkg::term_recip(k_reg);
            end
            default:
            begin
                mul_a = 32'(term_reg);
                mul_b = 32'(r_reg);
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign qk    = 35'(q_reg) * 35'(k_reg);
    assign rem   = 32'(35'(t_reg) - qk);
    assign q_fix = (rem >= 32'(k_reg)) ? q_reg + 31'd1 : q_reg;
    assign rnd   = 33'(sum_reg) + (33'd1 << (sh_reg - 5'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        g_reg     <= u[27:0];
                        sh_reg    <= 5'(6'd34 - 6'(u[32:28]));
                        state_reg <= E_FRAC;
                    end
                end
                E_FRAC:
                begin
                    r_reg     <= mul_p[57:28];
                    term_reg  <= 31'h40000000;
                    sum_reg   <= 32'h40000000;
                    k_reg     <= 4'd1;
                    state_reg <= E_TERM;
                end
                E_TERM:
                begin
                    t_reg     <= mul_p[60:30];
                    state_reg <= E_DIV;
                end
                E_DIV:
                begin
                    q_reg     <= mul_p[62:32];
                    state_reg <= E_FIX;
                end
                E_FIX:
                begin
                    term_reg <= q_fix;
                    sum_reg  <= sum_reg + 32'(q_fix);
                    k_reg    <= k_reg + 4'd1;
                    state_reg <= (k_reg == yrbd_pkg::TERM_LAST) ? E_ROUND : E_TERM;
                end
                E_ROUND:
                begin
                    result_reg <= 24'(rnd >> sh_reg);
                    done_reg   <= 1'b1;
                    state_reg  <= E_IDLE;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/yrbd_div.sv
// Restoring divider, one quotient bit per cycle, 36-bit dividend by 32-bit divisor.
// Stand-alone; used by yolo_region_box_decoder_unit.
module yrbd_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [35:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [35:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [35:0] quo_reg;
    logic [31:0] dvs_reg;

    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[35]};
    assign fits  = trial >= 33'(dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd36;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? 32'(trial - 33'(dvs_reg)) : trial[31:0];
                quo_reg <= {quo_reg[34:0], fits};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/yolo_region_box_decoder_unit.sv
// Region-layer box decoder, one box per run of entries; uses yrbd_pkg, yrbd_exp, yrbd_div.
// Coord and objectness entries are taken in ST_IDLE; a class entry keeps s_tready low (shared exp).
// The last class then runs the softmax exp and divider (if enabled), the confidence step,
// a centre multiply and divide and a size exp and multiply per axis, then the output states.
// Throughput: one entry at a time; s_tready is low while the sequencer works.
// Reset: asynchronous active-low; clears control and loads default register values.
module yolo_region_box_decoder_unit
#(
    parameter int MAX_CLASSES      = 128,
    parameter int ANCHORS_PER_CELL = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_value[15:0], cell_row[23:16], cell_col[31:24],
                                   // anchor_slot[33:32], zero pad
    input  logic [7:0]  s_tuser,   // entry_index[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // center_x[15:0], center_y[31:16], box_width[47:32],
                                   // box_height[63:48], class_id[70:64], confidence[85:71]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data
);

    localparam logic [7:0] MAX_CNT   = 8'(MAX_CLASSES);
    localparam logic [1:0] LAST_SLOT = 2'(ANCHORS_PER_CELL - 1);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_CEXP = 11'b00000000010,
        ST_PEXP = 11'b00000000100,
        ST_PDIV = 11'b00000001000,
        ST_CONF = 11'b00000010000,
        ST_CMUL = 11'b00000100000,
        ST_CDIV = 11'b00001000000,
        ST_SEXP = 11'b00010000000,
        ST_SMUL = 11'b00100000000,
        ST_OUT  = 11'b01000000000,
        ST_WAIT = 11'b10000000000
    } dec_state_t;

    dec_state_t state_reg;
    logic       issued_reg;
    logic       axis_reg;

    logic [12:0] thr_reg;
    logic [7:0]  cnt_reg;
    logic [7:0]  side_reg;
    logic [11:0] img_reg;
    logic        soft_reg;
    logic [59:0] anchor_reg;

    logic signed [15:0] coord_reg [yrbd_pkg::COORD_COUNT];
    logic signed [15:0] obj_reg;
    logic [6:0]         best_class_reg;
    logic signed [15:0] best_score_reg;
    logic [31:0]        exp_sum_reg;

    logic signed [15:0] v_reg;
    logic [6:0]         cls_idx_reg;
    logic               last_reg;
    logic [7:0]         row_reg;
    logic [7:0]         col_reg;
    logic [1:0]         slot_reg;

    logic [26:0] prob_reg;
    logic [6:0]  cls_reg;
    logic [14:0] conf_reg;
    logic [33:0] prod_reg;
    logic [15:0] cx_reg;
    logic [15:0] cy_reg;
    logic [15:0] bw_reg;
    logic [15:0] bh_reg;
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    logic signed [15:0] in_value;
    logic [7:0]         in_index;
    logic [7:0]         count;
    logic [8:0]         last_idx;
    logic               is_class;

    logic               exp_start;
    logic signed [15:0] exp_x;
    logic               exp_done;
    logic [23:0]        exp_res;
    logic               div_start;
    logic [35:0]        div_a;
    logic [31:0]        div_b;
    logic               div_done;
    logic [35:0]        div_q;

    logic [6:0]         nb_class;
    logic signed [15:0] nb_score;
    logic [31:0]        nb_sum;
    logic [32:0]        sum_add;

    logic [26:0] mul_a;
    logic [14:0] mul_b;
    logic [41:0] mul_p;
    logic [29:0] conf_raw;
    logic [14:0] conf_sat;

    logic [7:0]         cell_pos;
    logic signed [21:0] num;
    logic               num_pos;
    logic [7:0]         side_eff;
    logic [1:0]         slot_eff;
    logic [9:0]         anchor_dim;
    logic [15:0]        cent_q;
    logic [32:0]        size_rnd;
    logic [15:0]        size_q;

    assign in_value = s_tdata[15:0];
    assign in_index = s_tuser;
    assign count    = (cnt_reg == 8'd0) ? 8'd1 : ((cnt_reg > MAX_CNT) ? MAX_CNT : cnt_reg);
    assign last_idx = 9'(count) + 9'(yrbd_pkg::FIRST_CLASS_ENTRY - 1);
    assign is_class = (9'(in_index) >= 9'(yrbd_pkg::FIRST_CLASS_ENTRY)) &&
                      (9'(in_index) <= last_idx);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        case (state_reg)
            ST_CEXP: exp_x = v_reg;
            ST_PEXP: exp_x = best_score_reg;
            default: exp_x = axis_reg ? coord_reg[3] : coord_reg[2];
        endcase
    end

    assign exp_start = !issued_reg && ((state_reg == ST_CEXP) || (state_reg == ST_PEXP) ||
                                       (state_reg == ST_SEXP));
    assign div_start = !issued_reg && ((state_reg == ST_PDIV) || (state_reg == ST_CDIV));

    assign side_eff = (side_reg == 8'd0) ? 8'd1 : side_reg;

    always_comb
    begin
        if (state_reg == ST_PDIV)
        begin
            div_a = {exp_res, 12'd0};
            div_b = (exp_sum_reg == 32'd0) ? 32'd1 : exp_sum_reg;
        end
        else
        begin
            div_a = 36'(prod_reg) + 36'({side_eff, 7'd0});
            div_b = 32'({side_eff, 8'd0});
        end
    end

    yrbd_exp u_exp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .x      (exp_x),
        .done   (exp_done),
        .result (exp_res)
    );

    yrbd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // running arg-max and exponential sum
    assign sum_add = 33'(exp_sum_reg) + 33'(exp_res);
    always_comb
    begin
        if (cls_idx_reg == 7'd0)
        begin
            nb_class = 7'd0;
            nb_score = v_reg;
            nb_sum   = 32'(exp_res);
        end
        else
        begin
            nb_class = (v_reg > best_score_reg) ? cls_idx_reg : best_class_reg;
            nb_score = (v_reg > best_score_reg) ? v_reg : best_score_reg;
            nb_sum   = sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0];
        end
    end

    assign cell_pos = axis_reg ? row_reg : col_reg;
    assign num      = $signed({2'b00, cell_pos, 12'd0}) +
                      22'(axis_reg ? coord_reg[1] : coord_reg[0]);
    assign num_pos  = !num[21] && (num != 22'sd0);
    assign slot_eff = (slot_reg > LAST_SLOT) ? LAST_SLOT : slot_reg;
    assign anchor_dim = anchor_reg[6'(slot_eff) * 6'd20 + (axis_reg ? 6'd10 : 6'd0) +: 10];

    always_comb
    begin
        case (state_reg)
            ST_CONF:
            begin
                mul_a = prob_reg;
                mul_b = obj_reg[14:0];
            end
            ST_CMUL:
            begin
                mul_a = 27'(num[20:0]);
                mul_b = 15'(img_reg);
            end
            default:
            begin
                mul_a = 27'(exp_res);
                mul_b = 15'(anchor_dim);
            end
        endcase
    end

    assign mul_p    = 42'(mul_a) * 42'(mul_b);
    assign conf_raw = mul_p[41:12];
    assign conf_sat = (conf_raw > 30'(yrbd_pkg::SAT15)) ? yrbd_pkg::SAT15 : conf_raw[14:0];
    assign cent_q   = (div_q > 36'(yrbd_pkg::SAT16)) ? yrbd_pkg::SAT16 : div_q[15:0];
    assign size_rnd = 33'(mul_p[40:0] >> 8) + 33'(mul_p[7]);
    assign size_q   = (size_rnd > 33'(yrbd_pkg::SAT16)) ? yrbd_pkg::SAT16 : size_rnd[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= 13'd2048;
            cnt_reg    <= 8'd80;
            side_reg   <= 8'd13;
            img_reg    <= 12'd416;
            soft_reg   <= 1'b0;
            anchor_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                yrbd_pkg::CFG_THRESHOLD: thr_reg    <= cfg_data[12:0];
                yrbd_pkg::CFG_CLASSES:   cnt_reg    <= cfg_data[7:0];
                yrbd_pkg::CFG_GRID:      side_reg   <= cfg_data[7:0];
                yrbd_pkg::CFG_IMAGE:     img_reg    <= cfg_data[11:0];
                yrbd_pkg::CFG_SOFTMAX:   soft_reg   <= cfg_data[0];
                yrbd_pkg::CFG_ANCHORS:   anchor_reg <= cfg_data;
                default:                 thr_reg    <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid && in_index < 8'(yrbd_pkg::COORD_COUNT))
        begin
            coord_reg[in_index[1:0]] <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issued_reg     <= 1'b0;
            axis_reg       <= 1'b0;
            obj_reg        <= '0;
            best_class_reg <= '0;
            best_score_reg <= '0;
            exp_sum_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_WAIT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (exp_start || div_start)
            begin
                issued_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    issued_reg <= 1'b0;
                    if (s_tvalid)
                    begin
                        if (in_index == 8'(yrbd_pkg::COORD_COUNT))
                        begin
                            obj_reg <= in_value;
                        end
                        else if (is_class)
                        begin
                            v_reg       <= in_value;
                            cls_idx_reg <= 7'(in_index - 8'(yrbd_pkg::FIRST_CLASS_ENTRY));
                            last_reg    <= (9'(in_index) == last_idx);
                            row_reg     <= s_tdata[23:16];
                            col_reg     <= s_tdata[31:24];
                            slot_reg    <= s_tdata[33:32];
                            state_reg   <= ST_CEXP;
                        end
                    end
                end
                ST_CEXP:
                begin
                    if (exp_done)
                    begin
                        best_class_reg <= nb_class;
                        best_score_reg <= nb_score;
                        exp_sum_reg    <= nb_sum;
                        issued_reg     <= 1'b0;
                        cls_reg        <= nb_class;
                        if (!last_reg || (obj_reg < $signed({3'b000, thr_reg})))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (soft_reg)
                        begin
                            state_reg <= ST_PEXP;
                        end
                        else
                        begin
                            if (nb_score > 16'sd0)
                            begin
                                prob_reg <= 27'(nb_score[14:0]);
                            end
                            else
                            begin
                                prob_reg <= '0;
                                cls_reg  <= '0;
                            end
                            state_reg <= ST_CONF;
                        end
                    end
                end
                ST_PEXP:
                begin
                    if (exp_done)
                    begin
                        issued_reg <= 1'b0;
                        state_reg  <= ST_PDIV;
                    end
                end
                ST_PDIV:
                begin
                    if (div_done)
                    begin
                        prob_reg  <= (div_q[35:27] != 9'd0) ? {27{1'b1}} : div_q[26:0];
                        state_reg <= ST_CONF;
                    end
                end
                ST_CONF:
                begin
                    conf_reg   <= conf_sat;
                    axis_reg   <= 1'b0;
                    issued_reg <= 1'b0;
                    state_reg  <= (15'(thr_reg) > conf_sat) ? ST_IDLE : ST_CMUL;
                end
                ST_CMUL:
                begin
                    issued_reg <= 1'b0;
                    if (num_pos)
                    begin
                        prod_reg  <= mul_p[33:0];
                        state_reg <= ST_CDIV;
                    end
                    else
                    begin
                        if (axis_reg)
                        begin
                            cy_reg    <= '0;
                            axis_reg  <= 1'b0;
                            state_reg <= ST_SEXP;
                        end
                        else
                        begin
                            cx_reg   <= '0;
                            axis_reg <= 1'b1;
                        end
                    end
                end
                ST_CDIV:
                begin
                    if (div_done)
                    begin
                        issued_reg <= 1'b0;
                        if (axis_reg)
                        begin
                            cy_reg    <= cent_q;
                            axis_reg  <= 1'b0;
                            state_reg <= ST_SEXP;
                        end
                        else
                        begin
                            cx_reg    <= cent_q;
                            axis_reg  <= 1'b1;
                            state_reg <= ST_CMUL;
                        end
                    end
                end
                ST_SEXP:
                begin
                    if (exp_done)
                    begin
                        state_reg <= ST_SMUL;
                    end
                end
                ST_SMUL:
                begin
                    issued_reg <= 1'b0;
                    if (axis_reg)
                    begin
                        bh_reg    <= size_q;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        bw_reg    <= size_q;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_SEXP;
                    end
                end
                ST_OUT:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    // hold the result until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, conf_reg, cls_reg, bh_reg, bw_reg, cy_reg, cx_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
